@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Expression that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

@@ rtl/core/mst_pkg.sv @@
`timescale 1ns / 1ps
package mst_pkg;
    localparam int MAX_NODES   = 128;
    localparam int MAX_EDGES   = 4096;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int EIDX_W      = $clog2(MAX_EDGES);
    localparam int ECNT_W      = EIDX_W + 1;
    localparam int EDGE_W      = 8 + 8 + WEIGHT_BITS;

    typedef struct packed {
        logic load;
        logic start;
        logic res_take;
    } mst_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mst_stat_t;
endpackage

@@ rtl/core/mst_ram.sv @@
`timescale 1ns / 1ps
module mst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/mst_ctrl.sv @@
`timescale 1ns / 1ps
module mst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_last,
    input  logic              out_fire,
    input  mst_pkg::mst_stat_t stat,
    output mst_pkg::mst_cmd_t  cmd,
    output logic              in_ready,
    output logic              out_valid
);
    typedef enum logic [1:0] { S_LOAD, S_RUN, S_OUT } state_t;
    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_fire && in_last)
                    begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (stat.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_fire)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_LOAD);
    assign out_valid    = (state_reg == S_OUT);
    assign cmd.load     = in_fire;
    assign cmd.start    = in_fire && in_last;
    assign cmd.res_take = out_fire;
endmodule

@@ rtl/core/mst_dp.sv @@
`timescale 1ns / 1ps
// Datapath: edge store, insertion sort, Kruskal passes with union-find.
module mst_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  mst_pkg::mst_cmd_t  cmd,
    input  logic [7:0]         node_count,
    input  logic [7:0]         end_a,
    input  logic [7:0]         end_b,
    input  logic [15:0]        weight,
    output mst_pkg::mst_stat_t stat,
    output logic [15:0]        slimness,
    output logic               no_tree
);
    localparam int NW = mst_pkg::NODE_W;
    localparam int IW = mst_pkg::EIDX_W;
    localparam int CW = mst_pkg::ECNT_W;
    localparam int EW = mst_pkg::EDGE_W;
    localparam int WB = mst_pkg::WEIGHT_BITS;

    typedef enum logic [3:0] {
        D_IDLE, D_SO_NEXT, D_SO_CUR, D_SO_CMP, D_SO_CMPW, D_SO_PUT,
        D_PS_INIT, D_PS_RD, D_PS_EDGE, D_FA_RD, D_FA_CHK, D_CA_RD, D_CA_WR,
        D_JOIN, D_PS_END, D_DONE
    } dstate_t;

    dstate_t       st_reg;
    logic [CW-1:0] total_reg, i_reg, s_reg;
    logic [IW-1:0] j_reg;
    logic [NW-1:0] k_reg;
    logic [EW-1:0] cur_reg;
    logic [7:0]    n_reg, joined_reg;
    logic [NW:0]   v_reg, ra_reg, root_reg;
    logic          phase_b_reg;
    logic [WB-1:0] top_reg, wstart_reg;
    logic [WB:0]   best_reg;

    // edge memory
    logic          e_we;
    logic [IW-1:0] e_wa, e_ra;
    logic [EW-1:0] e_wd, e_rd;

    // parent memory, index is node-1
    logic          p_we;
    logic [NW-1:0] p_wa, p_ra;
    logic [NW-1:0] p_wd, p_rd;

    logic [WB-1:0] w_cur, w_rd;
    logic [NW:0]   p_node;
    logic [7:0]    rd_a, rd_b;
    logic          a_ok, b_ok;
    logic [CW-1:0] s_inc;
    logic          more_starts, first_start_ok, tree_done;
    logic [WB-1:0] cand;

    mst_ram #(.WIDTH(EW), .DEPTH(mst_pkg::MAX_EDGES)) u_edges (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));

    mst_ram #(.WIDTH(NW), .DEPTH(mst_pkg::MAX_NODES)) u_par (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    assign w_cur = cur_reg[EW-1 -: WB];
    assign w_rd  = e_rd[EW-1 -: WB];

    assign p_node = {1'b0, p_rd} + (NW+1)'(1);

    assign rd_a = e_rd[7:0];
    assign rd_b = e_rd[15:8];

    assign a_ok = (rd_a != 8'd0) && (rd_a <= n_reg);
    assign b_ok = (rd_b != 8'd0) && (rd_b <= n_reg);

    // a start position is tried only while the edges left from it are at least one fewer than the node count
    assign s_inc          = s_reg + CW'(1);
    assign more_starts    = ({1'b0, s_inc} + (CW+1)'(n_reg) - (CW+1)'(1))
                            <= {1'b0, total_reg};
    assign first_start_ok = ((CW+1)'(n_reg) - (CW+1)'(1)) <= {1'b0, total_reg};
    assign tree_done      = (joined_reg == n_reg - 8'd1);

    assign cand = top_reg - wstart_reg;

    always_comb
    begin
        e_we = 1'b0;
        e_wa = total_reg[IW-1:0];
        e_wd = {weight[WB-1:0], end_b, end_a};
        e_ra = i_reg[IW-1:0];
        p_we = 1'b0;
        p_wa = k_reg;
        p_wd = k_reg;
        p_ra = NW'(v_reg - (NW+1)'(1));
        case (st_reg)
            D_IDLE:
            begin
                e_we = cmd.load && (total_reg < CW'(mst_pkg::MAX_EDGES));
            end
            D_SO_CMP:
            begin
                e_ra = j_reg - IW'(1);
            end
            D_SO_CMPW:
            begin
                // shift the larger neighbor up one slot
                if (w_rd > w_cur)
                begin
                    e_we = 1'b1;
                    e_wa = j_reg;
                    e_wd = e_rd;
                end
            end
            D_SO_PUT:
            begin
                e_we = 1'b1;
                e_wa = j_reg;
                e_wd = cur_reg;
            end
            D_PS_INIT:
            begin
                p_we = 1'b1;
            end
            D_CA_WR:
            begin
                if (p_node != root_reg)
                begin
                    p_we = 1'b1;
                    p_wa = NW'(v_reg - (NW+1)'(1));
                    p_wd = NW'(root_reg - (NW+1)'(1));
                end
            end
            D_JOIN:
            begin
                p_we = 1'b1;
                p_wa = NW'(root_reg - (NW+1)'(1));
                p_wd = NW'(ra_reg - (NW+1)'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= D_IDLE;
            total_reg   <= '0;
            i_reg       <= '0;
            s_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            cur_reg     <= '0;
            n_reg       <= 8'd2;
            joined_reg  <= '0;
            v_reg       <= '0;
            ra_reg      <= '0;
            root_reg    <= '0;
            phase_b_reg <= 1'b0;
            top_reg     <= '0;
            wstart_reg  <= '0;
            best_reg    <= '1;
        end
        else
        begin
            unique case (st_reg)
                D_IDLE:
                begin
                    if (cmd.load && total_reg < CW'(mst_pkg::MAX_EDGES))
                    begin
                        total_reg <= total_reg + CW'(1);
                    end
                    if (cmd.start)
                    begin
                        n_reg  <= (node_count < 8'd2) ? 8'd2 :
                                  (node_count > 8'(mst_pkg::MAX_NODES)) ?
                                  8'(mst_pkg::MAX_NODES) : node_count;
                        i_reg  <= CW'(1);
                        st_reg <= D_SO_NEXT;
                    end
                end
                D_SO_NEXT:
                begin
                    if (i_reg >= total_reg)
                    begin
                        s_reg  <= '0;
                        k_reg  <= '0;
                        st_reg <= first_start_ok ? D_PS_INIT : D_DONE;
                    end
                    else
                    begin
                        st_reg <= D_SO_CUR;
                    end
                end
                D_SO_CUR:
                begin
                    cur_reg <= e_rd;
                    j_reg   <= i_reg[IW-1:0];
                    st_reg  <= D_SO_CMP;
                end
                D_SO_CMP:
                begin
                    st_reg <= (j_reg == '0) ? D_SO_PUT : D_SO_CMPW;
                end
                D_SO_CMPW:
                begin
                    if (w_rd > w_cur)
                    begin
                        j_reg  <= j_reg - IW'(1);
                        st_reg <= D_SO_CMP;
                    end
                    else
                    begin
                        st_reg <= D_SO_PUT;
                    end
                end
                D_SO_PUT:
                begin
                    i_reg  <= i_reg + CW'(1);
                    st_reg <= D_SO_NEXT;
                end
                D_PS_INIT:
                begin
                    k_reg <= k_reg + NW'(1);
                    if (8'(k_reg) == n_reg - 8'd1)
                    begin
                        i_reg      <= s_reg;
                        joined_reg <= '0;
                        top_reg    <= '0;
                        st_reg     <= D_PS_RD;
                    end
                end
                D_PS_RD:
                begin
                    st_reg <= (i_reg >= total_reg || tree_done) ? D_PS_END : D_PS_EDGE;
                end
                D_PS_EDGE:
                begin
                    if (i_reg == s_reg)
                    begin
                        wstart_reg <= w_rd;
                    end
                    cur_reg <= e_rd;
                    // drop self loops and endpoints outside the node range
                    if (a_ok && b_ok && rd_a != rd_b)
                    begin
                        v_reg       <= (NW+1)'(rd_a);
                        phase_b_reg <= 1'b0;
                        st_reg      <= D_FA_RD;
                    end
                    else
                    begin
                        i_reg  <= i_reg + CW'(1);
                        st_reg <= D_PS_RD;
                    end
                end
                D_FA_RD: st_reg <= D_FA_CHK;
                D_FA_CHK:
                begin
                    if (p_node == v_reg)
                    begin
                        root_reg <= v_reg;
                        // compress from the original endpoint
                        v_reg    <= phase_b_reg ? (NW+1)'(cur_reg[15:8])
                                                : (NW+1)'(cur_reg[7:0]);
                        st_reg   <= D_CA_RD;
                    end
                    else
                    begin
                        v_reg  <= p_node;
                        st_reg <= D_FA_RD;
                    end
                end
                D_CA_RD: st_reg <= D_CA_WR;
                D_CA_WR:
                begin
                    if (p_node == root_reg)
                    begin
                        if (!phase_b_reg)
                        begin
                            ra_reg      <= root_reg;
                            phase_b_reg <= 1'b1;
                            v_reg       <= (NW+1)'(cur_reg[15:8]);
                            st_reg      <= D_FA_RD;
                        end
                        else if (ra_reg != root_reg)
                        begin
                            st_reg <= D_JOIN;
                        end
                        else
                        begin
                            i_reg  <= i_reg + CW'(1);
                            st_reg <= D_PS_RD;
                        end
                    end
                    else
                    begin
                        v_reg  <= p_node;
                        st_reg <= D_CA_RD;
                    end
                end
                D_JOIN:
                begin
                    joined_reg <= joined_reg + 8'd1;
                    if (w_cur > top_reg)
                    begin
                        top_reg <= w_cur;
                    end
                    i_reg  <= i_reg + CW'(1);
                    st_reg <= D_PS_RD;
                end
                D_PS_END:
                begin
                    if (tree_done && ({1'b0, cand} < best_reg))
                    begin
                        best_reg <= {1'b0, cand};
                    end
                    s_reg  <= s_inc;
                    k_reg  <= '0;
                    st_reg <= more_starts ? D_PS_INIT : D_DONE;
                end
                D_DONE:
                begin
                    if (cmd.res_take)
                    begin
                        total_reg <= '0;
                        best_reg  <= '1;
                        st_reg    <= D_IDLE;
                    end
                end
                default: st_reg <= D_IDLE;
            endcase
        end
    end

    assign stat.busy = (st_reg != D_IDLE) && (st_reg != D_DONE);
    assign stat.done = (st_reg == D_DONE);
    assign slimness  = best_reg[WB] ? 16'd0 : 16'(best_reg[WB-1:0]);
    assign no_tree   = best_reg[WB];
endmodule

@@ rtl/core/min_slimness_spanning_tree.sv @@
`timescale 1ns / 1ps
// Minimum-slimness spanning tree engine.
// Slave channel s_axis_*: one edge request per beat, tdata = {weight, end_b, end_a},
// tlast marks the final edge of the graph. Edges load at one per cycle.
// After the last edge the block stops accepting requests and sorts the stored
// edges by insertion sort in the edge RAM, moving each edge down past every
// heavier one. Then it runs one Kruskal pass per start position: it sets up
// the parent RAM for node_count nodes (clamped to 2..128), scans the edges,
// runs a find with path compression per endpoint and joins differing roots.
// Master channel m_axis_*: one result, tdata = slimness, tuser = no_tree.
// The result is held until m_axis_tready; only then does loading resume.
// Reset (rst_n low, asynchronous) clears the edge count, sets the best value to all
// ones and sets node_count to 2. cfg_we/cfg_data write node_count; the user must do
// so only while idle, as the block itself does not enforce it.
module min_slimness_spanning_tree (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // end_a[7:0], end_b[15:8], weight[31:16]
    input  logic        s_axis_tlast,  // last_edge
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // slimness[15:0]
    output logic        m_axis_tuser   // no_tree
);
    `include "assert_macros.svh"

    logic [7:0] node_count_reg;
    mst_pkg::mst_cmd_t  cmd;
    mst_pkg::mst_stat_t stat;
    logic in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 8'd2;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_data;
        end
    end

    mst_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(s_axis_tlast),
        .out_fire(out_fire), .stat(stat), .cmd(cmd),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid));

    mst_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .node_count(node_count_reg),
        .end_a(s_axis_tdata[7:0]), .end_b(s_axis_tdata[15:8]),
        .weight(s_axis_tdata[31:16]), .stat(stat),
        .slimness(m_axis_tdata), .no_tree(m_axis_tuser));

    `ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(s_axis_tready && m_axis_tvalid),
        "input and output open together")
    `ASSERT_IMPL(a_busy_blocks, clk, rst_n, stat.busy, !s_axis_tready,
        "request taken while computing")
    `ASSERT_IMPL(a_notree_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == 16'd0, "slimness nonzero without tree")
endmodule
